[hdl/sjfq_pkg.sv]
// Shared types and constants for the shortest-job-first task queue.
// No dependencies; the interfaces and the top level use it.
`default_nettype none
package sjfq_pkg;

  // Default sizing for the top level.
  localparam int CAPACITY_DEF   = 32;
  localparam int BURST_BITS_DEF = 16;

  // Field widths of the channel words.
  localparam int CMD_W    = 1;
  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int KIND_W   = 2;
  localparam int FINISH_W = 21;
  localparam int SUM_W    = 26;
  localparam int COUNT_W  = 6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD = 1'b0;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // Add status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // One result word as it sits in the output register.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                status;
    logic [ID_W-1:0]     task_id;
    logic [BURST_W-1:0]  burst;
    logic [FINISH_W-1:0] finish;
    logic [SUM_W-1:0]    turn_sum;
    logic [SUM_W-1:0]    resp_sum;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

[hdl/sjfq_if.sv]
// Valid/ready channel interfaces for the task queue's input and result words.
// Depends on sjfq_pkg for the field widths.
`default_nettype none
interface sjfq_in_if;
  logic                          valid;
  logic                          ready;
  logic [sjfq_pkg::CMD_W-1:0]    cmd;
  logic [sjfq_pkg::ID_W-1:0]     task_id;
  logic [sjfq_pkg::BURST_W-1:0]  burst_len;

  modport source (output valid, output cmd, output task_id, output burst_len, input ready);
  modport sink   (input valid, input cmd, input task_id, input burst_len, output ready);
endinterface

interface sjfq_out_if;
  logic                          valid;
  logic                          ready;
  logic [sjfq_pkg::KIND_W-1:0]   kind;
  logic                          status;
  logic [sjfq_pkg::ID_W-1:0]     out_task_id;
  logic [sjfq_pkg::BURST_W-1:0]  out_burst;
  logic [sjfq_pkg::FINISH_W-1:0] finish_time;
  logic [sjfq_pkg::SUM_W-1:0]    turnaround_sum;
  logic [sjfq_pkg::SUM_W-1:0]    response_sum;
  logic [sjfq_pkg::COUNT_W-1:0]  run_count;
  logic                          last;

  modport source (output valid, output kind, output status, output out_task_id,
                  output out_burst, output finish_time, output turnaround_sum,
                  output response_sum, output run_count, output last, input ready);
  modport sink   (input valid, input kind, input status, input out_task_id,
                  input out_burst, input finish_time, input turnaround_sum,
                  input response_sum, input run_count, input last, output ready);
endinterface
`default_nettype wire

[hdl/sjf_sorted_task_queue_unit.sv]
// Shortest-job-first task queue. A full-table add, an empty-table add or run goes straight to
// its answer; any other add first walks the table, moving entries up, and then loads its answer.
// A run issues the first table read, then loads one word per cycle while the output is free,
// paced by the single table RAM read port; an output stall holds the run.
// Synchronous active-low reset clears the sequencer, occupancy and output valid;
// table contents are left as they are and only written entries are ever read.
`default_nettype none
module sjf_sorted_task_queue_unit #(
  parameter int CAPACITY   = sjfq_pkg::CAPACITY_DEF,
  parameter int BURST_BITS = sjfq_pkg::BURST_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sjfq_in_if.sink    in_ch,
  sjfq_out_if.source out_ch
);

  // Bursts are stored at the narrower of the configured width and the input field.
  localparam int SB = (BURST_BITS < sjfq_pkg::BURST_W) ? BURST_BITS : sjfq_pkg::BURST_W;
  // A table entry is {task id, burst}.
  localparam int EW = sjfq_pkg::ID_W + SB;
  // Index into the table, and the occupancy count that can also hold CAPACITY.
  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int FW = sjfq_pkg::FINISH_W;
  localparam int TW = sjfq_pkg::SUM_W;

  // The sequencer. The table is kept sorted by ascending burst. An add walks the
  // table from the top entry downward, moving each entry with a larger burst up
  // by one place, one entry per cycle, until it finds the slot for the new task.
  // Equal bursts stop the walk, so ties stay in arrival order.
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_ADD_CMP = 5'b00010,
    S_ADD_PUT = 5'b00100,
    S_RUN     = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic [sjfq_pkg::ID_W-1:0] new_id_r, new_id_nxt;
  logic [SB-1:0]     new_burst_r, new_burst_nxt;
  logic [sjfq_pkg::KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic              res_status_r, res_status_nxt;
  logic [FW-1:0]     finish_r, finish_nxt;
  logic [TW-1:0]     turn_r, turn_nxt;

  // Output register: a finished word waits here while the sequencer moves on.
  logic              ov_r, ov_nxt;
  sjfq_pkg::result_t out_r, out_nxt;

  // Table RAM ports.
  logic              we;
  logic [IW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic              re;
  logic [IW-1:0]     raddr;
  logic [EW-1:0]     rdata;

  logic [sjfq_pkg::ID_W-1:0] rd_id;
  logic [SB-1:0]     rd_burst;
  logic              out_free;
  logic [FW-1:0]     run_fin;
  logic [TW-1:0]     run_turn;
  logic              run_last;
  logic [IW-1:0]     ptr_up;
  logic [IW-1:0]     ptr_dn;
  logic [IW-1:0]     top_idx;
  logic [OW-1:0]     occ_inc;

  sjfq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_id    = rdata[EW-1:SB];
  assign rd_burst = rdata[SB-1:0];

  // The output register can take a word when it is empty or being drained now.
  assign out_free = !ov_r || out_ch.ready;

  // Running finish time and turnaround sum, both kept modulo their field widths.
  assign run_fin  = finish_r + FW'(rd_burst);
  assign run_turn = turn_r + TW'(run_fin);
  assign run_last = (OW'(ptr_r) + OW'(1)) == occ_r;

  assign ptr_up  = IW'(ptr_r + IW'(1));
  assign ptr_dn  = IW'(ptr_r - IW'(1));
  assign top_idx = IW'(occ_r - OW'(1));
  assign occ_inc = OW'(occ_r + OW'(1));

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    new_id_nxt     = new_id_r;
    new_burst_nxt  = new_burst_r;
    res_kind_nxt   = res_kind_r;
    res_status_nxt = res_status_r;
    finish_nxt     = finish_r;
    turn_nxt       = turn_r;
    ov_nxt         = ov_r && !out_ch.ready;
    out_nxt        = out_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    re             = 1'b0;
    raddr          = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == sjfq_pkg::CMD_ADD) begin
            new_id_nxt    = in_ch.task_id;
            new_burst_nxt = in_ch.burst_len[SB-1:0];
            res_kind_nxt  = sjfq_pkg::KIND_ADD;
            if (occ_r >= OW'(CAPACITY)) begin
              // Full table: drop the task and report it.
              res_status_nxt = sjfq_pkg::STAT_FULL;
              state_nxt      = S_RESP;
            end else if (occ_r == '0) begin
              res_status_nxt = sjfq_pkg::STAT_OK;
              we             = 1'b1;
              waddr          = '0;
              wdata          = {in_ch.task_id, in_ch.burst_len[SB-1:0]};
              occ_nxt        = occ_inc;
              state_nxt      = S_RESP;
            end else begin
              // Start the downward walk at the top entry.
              res_status_nxt = sjfq_pkg::STAT_OK;
              re             = 1'b1;
              raddr          = top_idx;
              ptr_nxt        = top_idx;
              state_nxt      = S_ADD_CMP;
            end
          end else begin
            if (occ_r == '0) begin
              res_kind_nxt   = sjfq_pkg::KIND_EMPTY;
              res_status_nxt = sjfq_pkg::STAT_OK;
              state_nxt      = S_RESP;
            end else begin
              re         = 1'b1;
              raddr      = '0;
              ptr_nxt    = '0;
              finish_nxt = '0;
              turn_nxt   = '0;
              state_nxt  = S_RUN;
            end
          end
        end
      end

      S_ADD_CMP: begin
        // The entry at ptr_r is on the RAM output; it either moves up or the
        // new task lands just above it.
        we    = 1'b1;
        waddr = ptr_up;
        if (rd_burst > new_burst_r) begin
          wdata = rdata;
          if (ptr_r == '0) begin
            state_nxt = S_ADD_PUT;
          end else begin
            ptr_nxt = ptr_dn;
            re      = 1'b1;
            raddr   = ptr_dn;
          end
        end else begin
          wdata     = {new_id_r, new_burst_r};
          occ_nxt   = occ_inc;
          state_nxt = S_RESP;
        end
      end

      S_ADD_PUT: begin
        // Every entry moved up; the new task becomes the head.
        we        = 1'b1;
        waddr     = '0;
        wdata     = {new_id_r, new_burst_r};
        occ_nxt   = occ_inc;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          ov_nxt         = 1'b1;
          out_nxt        = '0;
          out_nxt.kind   = res_kind_r;
          out_nxt.status = res_status_r;
          out_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RUN: begin
        // One entry per cycle while the output is free; the next read is issued as this word is loaded.
        // When the output is blocked the RAM holds its data.
        if (out_free) begin
          finish_nxt      = run_fin;
          turn_nxt        = run_turn;
          ov_nxt          = 1'b1;
          out_nxt         = '0;
          out_nxt.kind    = sjfq_pkg::KIND_RUN;
          out_nxt.task_id = rd_id;
          out_nxt.burst   = sjfq_pkg::BURST_W'(rd_burst);
          out_nxt.finish  = run_fin;
          if (run_last) begin
            out_nxt.turn_sum = run_turn;
            out_nxt.resp_sum = TW'(run_turn - TW'(run_fin));
            out_nxt.count    = sjfq_pkg::COUNT_W'(occ_r);
            out_nxt.last     = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            ptr_nxt = ptr_up;
            re      = 1'b1;
            raddr   = ptr_up;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    new_id_r     <= new_id_nxt;
    new_burst_r  <= new_burst_nxt;
    res_kind_r   <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    finish_r     <= finish_nxt;
    turn_r       <= turn_nxt;
    out_r        <= out_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.status         = out_r.status;
  assign out_ch.out_task_id    = out_r.task_id;
  assign out_ch.out_burst      = out_r.burst;
  assign out_ch.finish_time    = out_r.finish;
  assign out_ch.turnaround_sum = out_r.turn_sum;
  assign out_ch.response_sum   = out_r.resp_sum;
  assign out_ch.run_count      = out_r.count;
  assign out_ch.last           = out_r.last;

endmodule
`default_nettype wire

[hdl/sjfq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none
module sjfq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
